>>> sv/sap_pkg.sv
`default_nettype none

package sap_pkg;

    localparam int COORD_BITS = 14;
    localparam int SIDE_W     = 15;
    localparam int GLYPH_W    = 15;
    localparam int HEIGHT_W   = 15;
    localparam int FILL_W     = 15;
    localparam int RH_W       = 16;

    localparam logic [SIDE_W-1:0] SIDE_CAP           = SIDE_W'(1 << COORD_BITS);
    localparam logic [SIDE_W-1:0] RESET_INITIAL_SIDE = SIDE_W'(128);
    localparam logic [SIDE_W-1:0] RESET_MAX_SIDE     = SIDE_W'(8192);

    // h / 10 == (h * 52429) >> 19 for every h below 43690
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_SIDE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SIDE     = 2'd1;

    typedef enum logic [1:0] {
        STATUS_PLACED     = 2'd0,
        STATUS_MAX_SIZE   = 2'd1,
        STATUS_TABLE_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_GROW,
        ST_DONE
    } pack_state_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] top;
        logic [HEIGHT_W-1:0]   height;
        logic [FILL_W-1:0]     fill;
    } row_t;

endpackage

`default_nettype wire

>>> sv/shelf_atlas_packer_core.sv
// A request passes ST_DIV, then ST_SCAN over the stored rows, then ST_DONE when a row fits or the
// table is full; a new row or a failed growth also passes ST_GROW and its doubling steps before ST_DONE.
// Requests are taken one at a time, the next only after ST_DONE has moved the last result out;
// a finished result waits in its output register while the next request is taken.
// rst_n (async, active low) empties the row table, sets the side to 128 and max side to 8192.
// Writing initial_side also empties the row table; the row memory itself is never cleared.
`default_nettype none

module shelf_atlas_packer_core
    import sap_pkg::*;
#(
    parameter int MAX_ROWS = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,   // glyph_width[14:0], glyph_height[29:15]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [47:0]                 m_tdata,   // place_x[13:0], place_y[27:14], atlas_side[42:28]
    output logic [1:0]                  m_tuser,   // status[1:0]
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [SIDE_W-1:0]      cfg_data
);

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam logic [CNT_W-1:0] ROWS_FULL = CNT_W'(MAX_ROWS);

    pack_state_t state_reg, state_next;

    logic [GLYPH_W-1:0]    w_reg, w_next;
    logic [GLYPH_W-1:0]    h_reg, h_next;
    logic [RH_W-1:0]       rh_reg, rh_next;
    logic [ROW_AW-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]      row_count_reg, row_count_next;
    logic [SIDE_W-1:0]     nfy_reg, nfy_next;
    logic [SIDE_W-1:0]     side_reg, side_next;
    logic [SIDE_W-1:0]     max_side_reg, max_side_next;
    logic [COORD_BITS-1:0] res_x_reg, res_x_next;
    logic [COORD_BITS-1:0] res_y_reg, res_y_next;
    status_t               res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic [COORD_BITS-1:0] out_y_reg, out_y_next;
    status_t               out_status_reg, out_status_next;
    logic [SIDE_W-1:0]     out_side_reg, out_side_next;

    row_t              row_mem [MAX_ROWS];
    row_t              rd_data_reg;
    logic              mem_we;
    logic [ROW_AW-1:0] mem_waddr;
    row_t              mem_wdata;

    logic [18:0]       ten_h;
    logic [18:0]       seven_rh;
    logic [15:0]       fill_sum;
    logic              row_fits;
    logic              scan_last;
    logic [16:0]       new_bottom;
    logic              need_grow;
    logic              can_double;
    logic [SIDE_W-1:0] limit;
    logic [31:0]       div_prod;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_side_reg, out_y_reg, out_x_reg};
    assign m_tuser   = out_status_reg;

    assign limit    = (max_side_reg < SIDE_CAP) ? max_side_reg : SIDE_CAP;
    assign div_prod = 32'(h_reg) * 32'(DIV10_MUL);

    assign ten_h     = 19'({h_reg, 3'b000}) + 19'({h_reg, 1'b0});
    assign seven_rh  = 19'({rd_data_reg.height, 3'b000}) - 19'(rd_data_reg.height);
    assign fill_sum  = 16'(w_reg) + 16'(rd_data_reg.fill);
    assign row_fits  = (ten_h >= seven_rh) && ({1'b0, h_reg} <= 16'(rd_data_reg.height))
                       && (fill_sum <= 16'(side_reg));
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == row_count_reg);

    assign new_bottom = 17'(nfy_reg) + 17'(rh_reg);
    assign need_grow  = (new_bottom >= 17'(side_reg)) || (w_reg >= side_reg);
    assign can_double = (side_reg != '0) && ({side_reg, 1'b0} <= 16'(limit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= '0;
            nfy_reg       <= '0;
            side_reg      <= RESET_INITIAL_SIDE;
            max_side_reg  <= RESET_MAX_SIDE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            nfy_reg       <= nfy_next;
            side_reg      <= side_next;
            max_side_reg  <= max_side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        h_reg          <= h_next;
        rh_reg         <= rh_next;
        idx_reg        <= idx_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_status_reg <= res_status_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_status_reg <= out_status_next;
        out_side_reg   <= out_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= row_mem[idx_next];
    end

    always_comb
    begin
        state_next      = state_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        rh_next         = rh_reg;
        idx_next        = idx_reg;
        row_count_next  = row_count_reg;
        nfy_next        = nfy_reg;
        side_next       = side_reg;
        max_side_next   = max_side_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_status_next = out_status_reg;
        out_side_next   = out_side_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            priority if (cfg_index == CFG_INITIAL_SIDE)
            begin
                side_next      = (cfg_data > SIDE_CAP) ? SIDE_CAP : cfg_data;
                row_count_next = '0;
                nfy_next       = '0;
            end
            else if (cfg_index == CFG_MAX_SIDE)
            begin
                max_side_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    w_next          = s_tdata[GLYPH_W-1:0];
                    h_next          = s_tdata[2*GLYPH_W-1:GLYPH_W];
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_status_next = STATUS_PLACED;
                    state_next      = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rh_next  = 16'(h_reg) + 16'(div_prod >> DIV10_SHIFT);
                idx_next = '0;
                priority if (row_count_reg != '0)
                begin
                    state_next = ST_SCAN;
                end
                else if (row_count_reg == ROWS_FULL)
                begin
                    res_status_next = STATUS_TABLE_FULL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_GROW;
                end
            end

            ST_SCAN:
            begin
                priority if (row_fits)
                begin
                    res_x_next     = rd_data_reg.fill[COORD_BITS-1:0];
                    res_y_next     = rd_data_reg.top;
                    mem_we         = 1'b1;
                    mem_waddr      = idx_reg;
                    mem_wdata.fill = FILL_W'(fill_sum);
                    state_next     = ST_DONE;
                end
                else if (scan_last)
                begin
                    if (row_count_reg == ROWS_FULL)
                    begin
                        res_status_next = STATUS_TABLE_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_GROW;
                    end
                end
                else
                begin
                    idx_next = idx_reg + ROW_AW'(1);
                end
            end

            ST_GROW:
            begin
                priority if (!need_grow)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = row_count_reg[ROW_AW-1:0];
                    mem_wdata.top    = nfy_reg[COORD_BITS-1:0];
                    mem_wdata.height = rh_reg[HEIGHT_W-1:0];
                    mem_wdata.fill   = w_reg;
                    res_x_next       = '0;
                    res_y_next       = nfy_reg[COORD_BITS-1:0];
                    nfy_next         = new_bottom[SIDE_W-1:0];
                    row_count_next   = row_count_reg + CNT_W'(1);
                    state_next       = ST_DONE;
                end
                else if (can_double)
                begin
                    side_next = {side_reg[SIDE_W-2:0], 1'b0};
                end
                else
                begin
                    res_status_next = STATUS_MAX_SIZE;
                    state_next      = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_x_next      = res_x_reg;
                    out_y_next      = res_y_reg;
                    out_status_next = res_status_reg;
                    out_side_next   = side_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
